// File: rtl/smi_pkg.sv
// Shared widths, product index tables and pipeline meta types for the small
// matrix inverse unit. No dependencies; used by every file under rtl.
package smi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_ORDER = 3;
   localparam int NUM_ELEM  = 9;
   localparam int NUM_PROD  = 2 * NUM_ELEM;
   localparam int ROW_N     = 3;

   localparam int ELEM_W   = 32;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int COF_W    = PROD_W + 1;
   localparam int CMAG_W   = PROD_W;
   localparam int HALF_W   = CMAG_W / 2;
   localparam int TERM_W   = ELEM_W + CMAG_W;
   localparam int DET_W    = TERM_W + 3;
   localparam int DMAG_W   = DET_W - 1;
   localparam int ORDER_W  = 2;
   localparam int THRESH_W = 31;
   localparam int LIM_W    = THRESH_W + (MAX_ORDER - 1) * FRAC_BITS;
   localparam int NUM_W    = CMAG_W + 2 * FRAC_BITS + 1;
   localparam int REM_W    = (NUM_W > DMAG_W ? NUM_W : DMAG_W) + 1;
   localparam int QUOT_W   = ELEM_W + 1;
   localparam int WIDE_W   = REM_W + QUOT_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = THRESH_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORDER  = 1'b0,
      CSR_THRESH = 1'b1
   } csr_index_type;

   typedef logic [3:0] elem_idx_type;

   // cofactor k = prod[2k] - prod[2k+1], prod[p] = a[PROD_L[p]] * a[PROD_R[p]]
   localparam elem_idx_type PROD_L [NUM_PROD] = '{
      4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
      4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
   localparam elem_idx_type PROD_R [NUM_PROD] = '{
      4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
      4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

   typedef struct packed {
      logic                singular;
      logic [NUM_ELEM-1:0] neg;
      logic [NUM_ELEM-1:0] ovf;
   } smi_meta_type;

endpackage

// File: rtl/smi_divider.sv
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient
// bit per stage. Depends on smi_pkg.
module smi_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [smi_pkg::REM_W-1:0]         in_num  [smi_pkg::NUM_ELEM],
   input  logic [smi_pkg::REM_W-1:0]         in_div,
   input  smi_pkg::smi_meta_type             in_meta,
   output logic                              out_valid,
   output logic [smi_pkg::QUOT_W-1:0]        out_quot [smi_pkg::NUM_ELEM],
   output smi_pkg::smi_meta_type             out_meta
);

   localparam int QW = smi_pkg::QUOT_W;
   localparam int NE = smi_pkg::NUM_ELEM;

   logic [smi_pkg::REM_W-1:0]  rem_ff  [QW][NE];
   logic [QW-1:0]              quot_ff [QW][NE];
   logic [smi_pkg::REM_W-1:0]  div_ff  [QW];
   smi_pkg::smi_meta_type      meta_ff [QW];
   logic [QW-1:0]              valid_ff;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [smi_pkg::REM_W-1:0]  rem_src  [NE];
      logic [QW-1:0]              quot_src [NE];
      logic [smi_pkg::REM_W-1:0]  div_src;
      smi_pkg::smi_meta_type      meta_src;
      logic                       valid_src;
      logic [smi_pkg::REM_W-1:0]  rem_in   [NE];
      logic [QW-1:0]              quot_in  [NE];
      logic [smi_pkg::WIDE_W-1:0] step;

      if (s == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < NE; k++) begin
               rem_src[k]  = in_num[k];
               quot_src[k] = '0;
            end
         end
         assign div_src   = in_div;
         assign meta_src  = in_meta;
         assign valid_src = in_valid;
      end else begin : g_next
         always_comb begin
            for (int k = 0; k < NE; k++) begin
               rem_src[k]  = rem_ff[s-1][k];
               quot_src[k] = quot_ff[s-1][k];
            end
         end
         assign div_src   = div_ff[s-1];
         assign meta_src  = meta_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      assign step = smi_pkg::WIDE_W'(div_src) << (QW - 1 - s);

      // subtract the shifted divisor where it fits and set this stage's bit
      always_comb begin
         for (int k = 0; k < NE; k++) begin
            if (smi_pkg::WIDE_W'(rem_src[k]) >= step) begin
               rem_in[k]  = smi_pkg::REM_W'(smi_pkg::WIDE_W'(rem_src[k]) - step);
               quot_in[k] = quot_src[k] | (QW'(1) << (QW - 1 - s));
            end else begin
               rem_in[k]  = rem_src[k];
               quot_in[k] = quot_src[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < NE; k++) begin
               rem_ff[s][k]  <= rem_in[k];
               quot_ff[s][k] <= quot_in[k];
            end
            div_ff[s]  <= div_src;
            meta_ff[s] <= meta_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_meta  = meta_ff[QW-1];
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         out_quot[k] = quot_ff[QW-1][k];
      end
   end

endmodule

// File: rtl/small_matrix_inverse_unit.sv
// Top level of the small matrix inverse unit: cofactor, determinant and
// threshold stages, then the divider pipeline and an output skid register.
// Depends on smi_pkg and smi_divider.
//
// Usage: each req beat carries a 3x3 frame of signed Q16.16 elements; the
// csr port selects the order (1..3) and the singular threshold and may be
// written only while the unit is empty. Each rsp beat carries the inverse,
// saturated to Q16.16, with zeros outside the active order, plus the
// singular and saturated flags.
// Path: a req beat passes six datapath stages, 33 divider stages (one
// quotient bit each) and the output register before it shows as a rsp beat.
// Throughput: one matrix per cycle while the receiver does not stall, set
// by the fully pipelined divider.
// Stall: when rsp_ready is low the output register holds its beat and one
// more beat lands in the skid register; then req_ready drops and the whole
// pipeline freezes without losing or repeating a beat.
// Reset: synchronous; clears every valid bit, order becomes 3, threshold 1.
module small_matrix_inverse_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a00,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a01,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a02,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a10,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a11,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a12,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a20,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a21,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_a22,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b00,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b01,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b02,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b10,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b11,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b12,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b20,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b21,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_b22,
   output logic                                rsp_singular,
   output logic                                rsp_saturated,
   input  logic                                csr_wen,
   input  logic [smi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NE = smi_pkg::NUM_ELEM;
   localparam int EW = smi_pkg::ELEM_W;
   localparam int F  = smi_pkg::FRAC_BITS;
   localparam int QW = smi_pkg::QUOT_W;

   typedef logic signed [smi_pkg::PROD_W-1:0] prod_type;
   typedef logic signed [smi_pkg::COF_W-1:0]  cof_type;
   typedef logic signed [smi_pkg::DET_W-1:0]  det_type;

   typedef struct packed {
      logic [NE-1:0][EW-1:0] elem;
      logic                  singular;
      logic                  saturated;
   } rsp_type;

   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (EW - 1);
   localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);
   localparam logic [EW-1:0] NEG_MIN = EW'(1) << (EW - 1);
   localparam logic [EW-1:0] POS_MAX = NEG_MIN - EW'(1);

   // configuration
   logic [smi_pkg::ORDER_W-1:0]  order_ff;
   logic [smi_pkg::THRESH_W-1:0] thresh_ff;
   logic [smi_pkg::ORDER_W-1:0]  order_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= smi_pkg::ORDER_W'(3);
         thresh_ff <= smi_pkg::THRESH_W'(1);
      end else if (csr_wen) begin
         case (smi_pkg::csr_index_type'(csr_index))
            smi_pkg::CSR_ORDER:  order_ff  <= csr_wdata[smi_pkg::ORDER_W-1:0];
            smi_pkg::CSR_THRESH: thresh_ff <= csr_wdata[smi_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (order_ff == '0) begin
         order_eff = smi_pkg::ORDER_W'(1);
      end else if (order_ff > smi_pkg::ORDER_W'(smi_pkg::MAX_ORDER)) begin
         order_eff = smi_pkg::ORDER_W'(smi_pkg::MAX_ORDER);
      end else begin
         order_eff = order_ff;
      end
   end

   // pipeline advance: frozen only while the skid register is full
   logic skid_valid_ff;
   logic en;
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // stage 1: element products
   logic signed [EW-1:0] in_elem [NE];
   prod_type             prod_in [smi_pkg::NUM_PROD];
   logic                 s1_valid_ff;
   logic signed [EW-1:0] s1_elem_ff [NE];
   prod_type             s1_prod_ff [smi_pkg::NUM_PROD];

   always_comb begin
      in_elem = '{req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
                  req_a20, req_a21, req_a22};
      for (int p = 0; p < smi_pkg::NUM_PROD; p++) begin
         prod_in[p] = prod_type'(in_elem[smi_pkg::PROD_L[p]])
                    * prod_type'(in_elem[smi_pkg::PROD_R[p]]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_elem_ff <= in_elem;
         s1_prod_ff <= prod_in;
      end
   end

   // stage 2: cofactors for the active order
   cof_type              cof3 [NE];
   cof_type              cof_in [NE];
   cof_type              detlo_in;
   logic                 s2_valid_ff;
   cof_type              s2_cof_ff [NE];
   cof_type              s2_detlo_ff;
   logic signed [EW-1:0] s2_row_ff [smi_pkg::ROW_N];

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         cof3[k] = cof_type'(s1_prod_ff[2*k]) - cof_type'(s1_prod_ff[2*k+1]);
         cof_in[k] = '0;
      end
      case (order_eff)
         smi_pkg::ORDER_W'(1): begin
            cof_in[0] = cof_type'(1);
            detlo_in  = cof_type'(s1_elem_ff[0]);
         end
         smi_pkg::ORDER_W'(2): begin
            cof_in[0] = cof_type'(s1_elem_ff[4]);
            cof_in[1] = -cof_type'(s1_elem_ff[1]);
            cof_in[3] = -cof_type'(s1_elem_ff[3]);
            cof_in[4] = cof_type'(s1_elem_ff[0]);
            detlo_in  = cof3[8];
         end
         default: begin
            cof_in   = cof3;
            detlo_in = cof3[8];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_cof_ff   <= cof_in;
         s2_detlo_ff <= detlo_in;
         for (int j = 0; j < smi_pkg::ROW_N; j++) begin
            s2_row_ff[j] <= s1_elem_ff[j];
         end
      end
   end

   // stage 3: row 0 expansion, split into 32x32 partial products
   logic [smi_pkg::PROD_W-1:0] pplo_in  [smi_pkg::ROW_N];
   logic [smi_pkg::PROD_W-1:0] pphi_in  [smi_pkg::ROW_N];
   logic [smi_pkg::ROW_N-1:0]  ppneg_in;
   logic [EW-1:0]              amag;
   cof_type                    cexp;
   logic [smi_pkg::CMAG_W-1:0] cmag3;
   logic                       s3_valid_ff;
   logic [smi_pkg::PROD_W-1:0] s3_pplo_ff [smi_pkg::ROW_N];
   logic [smi_pkg::PROD_W-1:0] s3_pphi_ff [smi_pkg::ROW_N];
   logic [smi_pkg::ROW_N-1:0]  s3_ppneg_ff;
   cof_type                    s3_cof_ff [NE];
   cof_type                    s3_detlo_ff;

   always_comb begin
      for (int j = 0; j < smi_pkg::ROW_N; j++) begin
         amag  = s2_row_ff[j][EW-1] ? EW'(-s2_row_ff[j]) : EW'(s2_row_ff[j]);
         cexp  = s2_cof_ff[smi_pkg::ROW_N * j];
         cmag3 = cexp[smi_pkg::COF_W-1] ? smi_pkg::CMAG_W'(-cexp)
                                        : smi_pkg::CMAG_W'(cexp);
         pplo_in[j]  = smi_pkg::PROD_W'(amag)
                     * smi_pkg::PROD_W'(cmag3[smi_pkg::HALF_W-1:0]);
         pphi_in[j]  = smi_pkg::PROD_W'(amag)
                     * smi_pkg::PROD_W'(cmag3[smi_pkg::CMAG_W-1:smi_pkg::HALF_W]);
         ppneg_in[j] = s2_row_ff[j][EW-1] ^ cexp[smi_pkg::COF_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pplo_ff  <= pplo_in;
         s3_pphi_ff  <= pphi_in;
         s3_ppneg_ff <= ppneg_in;
         s3_cof_ff   <= s2_cof_ff;
         s3_detlo_ff <= s2_detlo_ff;
      end
   end

   // stage 4: determinant
   logic [smi_pkg::TERM_W-1:0] term;
   det_type                    sterm;
   det_type                    det3;
   det_type                    det_in;
   logic                       s4_valid_ff;
   det_type                    s4_det_ff;
   cof_type                    s4_cof_ff [NE];

   always_comb begin
      det3 = '0;
      for (int j = 0; j < smi_pkg::ROW_N; j++) begin
         term  = (smi_pkg::TERM_W'(s3_pphi_ff[j]) << smi_pkg::HALF_W)
               + smi_pkg::TERM_W'(s3_pplo_ff[j]);
         sterm = $signed(smi_pkg::DET_W'(term));
         if (s3_ppneg_ff[j]) begin
            sterm = -sterm;
         end
         det3 = det3 + sterm;
      end
      det_in = (order_eff == smi_pkg::ORDER_W'(3)) ? det3 : det_type'(s3_detlo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_det_ff <= det_in;
         s4_cof_ff <= s3_cof_ff;
      end
   end

   // stage 5: magnitudes, signs and the singular test
   logic                       det_neg;
   det_type                    det_abs;
   logic [smi_pkg::DMAG_W-1:0] dmag_in;
   logic [smi_pkg::LIM_W-1:0]  lim;
   logic                       singular_in;
   logic [smi_pkg::CMAG_W-1:0] cmag_in [NE];
   logic [NE-1:0]              neg_in;
   logic                       s5_valid_ff;
   logic [smi_pkg::DMAG_W-1:0] s5_dmag_ff;
   logic [smi_pkg::CMAG_W-1:0] s5_cmag_ff [NE];
   logic [NE-1:0]              s5_neg_ff;
   logic                       s5_singular_ff;

   always_comb begin
      det_neg = s4_det_ff[smi_pkg::DET_W-1];
      det_abs = det_neg ? -s4_det_ff : s4_det_ff;
      dmag_in = det_abs[smi_pkg::DMAG_W-1:0];
      case (order_eff)
         smi_pkg::ORDER_W'(1): lim = smi_pkg::LIM_W'(thresh_ff);
         smi_pkg::ORDER_W'(2): lim = smi_pkg::LIM_W'(thresh_ff) << F;
         default:              lim = smi_pkg::LIM_W'(thresh_ff) << (2 * F);
      endcase
      singular_in = (s4_det_ff == '0) || (dmag_in < smi_pkg::DMAG_W'(lim));
      for (int k = 0; k < NE; k++) begin
         cmag_in[k] = s4_cof_ff[k][smi_pkg::COF_W-1] ? smi_pkg::CMAG_W'(-s4_cof_ff[k])
                                                      : smi_pkg::CMAG_W'(s4_cof_ff[k]);
         neg_in[k]  = s4_cof_ff[k][smi_pkg::COF_W-1] ^ det_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_dmag_ff     <= dmag_in;
         s5_cmag_ff     <= cmag_in;
         s5_neg_ff      <= neg_in;
         s5_singular_ff <= singular_in;
      end
   end

   // stage 6: rounded numerators (2|c|*2^2F + |D|) over 2|D|, overflow precheck
   logic [smi_pkg::REM_W-1:0] num_in [NE];
   logic [smi_pkg::REM_W-1:0] div_in;
   smi_pkg::smi_meta_type     meta_in;
   logic                      s6_valid_ff;
   logic [smi_pkg::REM_W-1:0] s6_num_ff [NE];
   logic [smi_pkg::REM_W-1:0] s6_div_ff;
   smi_pkg::smi_meta_type     s6_meta_ff;

   always_comb begin
      div_in           = smi_pkg::REM_W'({s5_dmag_ff, 1'b0});
      meta_in.singular = s5_singular_ff;
      meta_in.neg      = s5_neg_ff;
      for (int k = 0; k < NE; k++) begin
         num_in[k] = (smi_pkg::REM_W'(s5_cmag_ff[k]) << (2 * F + 1))
                   + smi_pkg::REM_W'(s5_dmag_ff);
         meta_in.ovf[k] = smi_pkg::WIDE_W'(num_in[k])
                        >= (smi_pkg::WIDE_W'(div_in) << QW);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_num_ff  <= num_in;
         s6_div_ff  <= div_in;
         s6_meta_ff <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // divider pipeline
   logic                  div_valid;
   logic [QW-1:0]         div_quot [NE];
   smi_pkg::smi_meta_type div_meta;

   smi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_num    (s6_num_ff),
      .in_div    (s6_div_ff),
      .in_meta   (s6_meta_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_meta  (div_meta)
   );

   // saturate and sign the quotients
   rsp_type       res;
   logic [NE-1:0] sat_vec;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         sat_vec[k] = 1'b0;
         if (div_meta.singular) begin
            res.elem[k] = '0;
         end else if (div_meta.neg[k]) begin
            if (div_meta.ovf[k] || (div_quot[k] > NEG_LIM)) begin
               sat_vec[k]  = 1'b1;
               res.elem[k] = NEG_MIN;
            end else begin
               res.elem[k] = EW'(-div_quot[k]);
            end
         end else begin
            if (div_meta.ovf[k] || (div_quot[k] > POS_LIM)) begin
               sat_vec[k]  = 1'b1;
               res.elem[k] = POS_MAX;
            end else begin
               res.elem[k] = div_quot[k][EW-1:0];
            end
         end
      end
      res.singular  = div_meta.singular;
      res.saturated = |sat_vec;
   end

   // output register with skid
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= div_valid;
         end else if (div_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (rsp_ready) begin
         // drain the skid beat into the output register
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_b00       = $signed(rsp_ff.elem[0]);
   assign rsp_b01       = $signed(rsp_ff.elem[1]);
   assign rsp_b02       = $signed(rsp_ff.elem[2]);
   assign rsp_b10       = $signed(rsp_ff.elem[3]);
   assign rsp_b11       = $signed(rsp_ff.elem[4]);
   assign rsp_b12       = $signed(rsp_ff.elem[5]);
   assign rsp_b20       = $signed(rsp_ff.elem[6]);
   assign rsp_b21       = $signed(rsp_ff.elem[7]);
   assign rsp_b22       = $signed(rsp_ff.elem[8]);
   assign rsp_singular  = rsp_ff.singular;
   assign rsp_saturated = rsp_ff.saturated;

endmodule

// File: rtl/smi_checker.sv
// Port-level checks for the small matrix inverse unit, bound to its top level.
// Depends on smi_pkg and small_matrix_inverse_unit.
module smi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b00,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b01,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b02,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b10,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b11,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b12,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b20,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b21,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_b22,
   input logic                              rsp_singular,
   input logic                              rsp_saturated
);

   // hold a stalled beat: valid, diagonal elements and flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_b00) && $stable(rsp_b11)
         && $stable(rsp_b22) && $stable(rsp_singular) && $stable(rsp_saturated))
      else $error("stalled rsp beat changed");

   // a singular beat carries zeros and no saturation
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_b00 == '0 && rsp_b01 == '0
         && rsp_b02 == '0 && rsp_b10 == '0 && rsp_b11 == '0 && rsp_b12 == '0
         && rsp_b20 == '0 && rsp_b21 == '0 && rsp_b22 == '0)
      else $error("singular beat with nonzero payload");

   // input backpressure only while the output register is occupied
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   // drop all beats at reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind small_matrix_inverse_unit smi_checker u_checker (.*);

// File: tb/small_matrix_inverse_unit_tb.sv
// Self-checking bench for small_matrix_inverse_unit: directed table, then random matrices
// under several order/threshold settings; expected values come from the table or an exact
// 128-bit inverse predictor. Depends on smi_pkg and the unit RTL only.
module small_matrix_inverse_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] ONE       = 32'h0001_0000;
   localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX_NEG   = 32'h8000_0000;
   localparam logic [30:0] THR_MAX   = 31'h7FFF_FFFF;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          RAND_ITEMS = 2000;
   localparam int          PHASES     = 8;

   typedef struct {
      logic signed [31:0] b [9];
      logic               singular;
      logic               saturated;
   } inv_result_type;

   typedef struct packed {
      logic [1:0]         order;
      logic [30:0]        thresh;
      logic [0:8][31:0]   m;
      logic               typed;
      logic [31:0]        diag;
      logic               sing;
      logic               sat;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [31:0] req_a00, req_a01, req_a02, req_a10, req_a11, req_a12;
   logic signed [31:0] req_a20, req_a21, req_a22;
   logic signed [31:0] rsp_b00, rsp_b01, rsp_b02, rsp_b10, rsp_b11, rsp_b12;
   logic signed [31:0] rsp_b20, rsp_b21, rsp_b22;
   logic rsp_singular, rsp_saturated;
   logic csr_wen;
   logic [smi_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [smi_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic [1:0]     cur_order;
   logic [30:0]    cur_thresh;
   inv_result_type inverse_q [$];
   int             fail_count, beats_in, beats_out, singular_seen, sat_seen, idle_cycles;

   small_matrix_inverse_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // exact inverse: adjugate * 2^32 / det, rounded half away from zero, saturated
   function automatic inv_result_type predict_inverse(input logic [0:8][31:0] m);
      logic signed [127:0] e [9];
      logic signed [127:0] cof [9];
      logic signed [127:0] det, dmag, num, q;
      logic [127:0]        lim;
      int                  n;
      logic                neg;
      inv_result_type      r;
      for (int k = 0; k < 9; k++) begin
         e[k]   = 128'(signed'(m[k]));
         cof[k] = '0;
      end
      n = (cur_order == 0) ? 1 : int'(cur_order);
      if (n == 1) begin
         cof[0] = 1;
         det    = e[0];
      end else if (n == 2) begin
         cof[0] = e[4];
         cof[1] = -e[1];
         cof[3] = -e[3];
         cof[4] = e[0];
         det    = e[0] * e[4] - e[1] * e[3];
      end else begin
         cof[0] = e[4] * e[8] - e[5] * e[7];
         cof[1] = e[2] * e[7] - e[1] * e[8];
         cof[2] = e[1] * e[5] - e[2] * e[4];
         cof[3] = e[5] * e[6] - e[3] * e[8];
         cof[4] = e[0] * e[8] - e[2] * e[6];
         cof[5] = e[2] * e[3] - e[0] * e[5];
         cof[6] = e[3] * e[7] - e[4] * e[6];
         cof[7] = e[1] * e[6] - e[0] * e[7];
         cof[8] = e[0] * e[4] - e[1] * e[3];
         det    = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
      end
      lim  = 128'(cur_thresh) << ((n - 1) * smi_pkg::FRAC_BITS);
      dmag = (det < 0) ? -det : det;
      r.singular  = (det == 0) || (128'(dmag) < lim);
      r.saturated = 1'b0;
      for (int k = 0; k < 9; k++) begin
         if (r.singular) begin
            r.b[k] = '0;
         end else begin
            num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * smi_pkg::FRAC_BITS);
            neg = (cof[k] < 0) != (det < 0);
            q   = (2 * num + dmag) / (2 * dmag);
            if (neg) begin
               if (q > 128'sh8000_0000) begin
                  r.b[k] = MAX_NEG;
                  r.saturated = 1'b1;
               end else begin
                  r.b[k] = -q[31:0];
               end
            end else if (q > 128'sh7FFF_FFFF) begin
               r.b[k] = MAX_POS;
               r.saturated = 1'b1;
            end else begin
               r.b[k] = q[31:0];
            end
         end
      end
      return r;
   endfunction

   task automatic drain_and_configure(input logic [1:0] order, input logic [30:0] thresh);
      req_valid <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= smi_pkg::CSR_ORDER;
      csr_wdata <= smi_pkg::CSR_DATA_W'(order);
      @(posedge clock);
      csr_index <= smi_pkg::CSR_THRESH;
      csr_wdata <= thresh;
      @(posedge clock);
      csr_wen    <= 1'b0;
      cur_order  = order;
      cur_thresh = thresh;
   endtask

   task automatic send_matrix(input logic [0:8][31:0] m, input int gap,
                              input logic typed, input inv_result_type typed_res);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
       req_a20, req_a21, req_a22} <= m;
      do @(posedge clock); while (!req_ready);
      beats_in++;
      inverse_q.push_back(typed ? typed_res : predict_inverse(m));
   endtask

   function automatic logic [31:0] rand_elem(input int mode);
      case (mode)
         0, 1:    return $urandom;
         9:       return 32'($urandom_range(0, 511)) - 32'd256;
         default: return 32'($urandom_range(0, 524288)) - 32'd262144;
      endcase
   endfunction

   // result channel: random stalls, quiet stretches and one long hold-off
   initial begin
      inv_result_type     want;
      logic signed [31:0] got [9];
      int                 stall;
      logic               quiet;
      quiet = 1'b0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (beats_out % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         stall = quiet ? 0 : $urandom_range(0, 4);
         // hold off mid-phase so the sender can fill the pipeline
         if (beats_out == 400) stall = 150;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats_out++;
         got = '{rsp_b00, rsp_b01, rsp_b02, rsp_b10, rsp_b11, rsp_b12,
                 rsp_b20, rsp_b21, rsp_b22};
         if (inverse_q.size() == 0) begin
            $error("unexpected rsp beat with nothing outstanding");
            fail_count++;
         end else begin
            want = inverse_q.pop_front();
            if (want.singular) singular_seen++;
            if (want.saturated) sat_seen++;
            for (int k = 0; k < 9; k++)
               if (got[k] !== want.b[k]) begin
                  $error("b%0d%0d: expected %h, actual %h", k / 3, k % 3, want.b[k], got[k]);
                  fail_count++;
               end
            if (rsp_singular !== want.singular) begin
               $error("singular: expected %b, actual %b", want.singular, rsp_singular);
               fail_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %b, actual %b", want.saturated, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL small_matrix_inverse_unit");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type       rows [19];
      inv_result_type     typed_res;
      logic [0:8][31:0]   m;
      logic [1:0]         phase_order [PHASES];
      int                 n, mode, gap, wait_cycles;
      logic               quiet;
      phase_order = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
      rows = '{
         '{2'd3, 31'd1, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE},
           1'b1, ONE, 1'b0, 1'b0},
         '{2'd3, 31'd1, {9{32'd0}}, 1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd3, 31'd1, {9{MAX_POS}}, 1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd3, 31'd1, {9{MAX_NEG}}, 1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd3, 31'd1, {2 * ONE, 32'd0, 32'd0, 32'd0, 2 * ONE, 32'd0, 32'd0, 32'd0, 2 * ONE},
           1'b1, 32'h8000, 1'b0, 1'b0},
         '{2'd3, 31'd1, {ONE, 2 * ONE, 3 * ONE, 32'd0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 32'd0},
           1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd3, 31'd1, {MAX_NEG, 32'd0, 32'd0, 32'd0, MAX_NEG, 32'd0, 32'd0, 32'd0, MAX_NEG},
           1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd3, 31'd0, {9{32'd0}}, 1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd3, THR_MAX, {MAX_POS, 32'd0, 32'd0, 32'd0, MAX_POS, 32'd0, 32'd0, 32'd0, MAX_POS},
           1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd2, 31'd1, {ONE, 32'd0, 32'h1234, 32'd0, ONE, 32'hFFFF, 32'd7, 32'd9, MAX_NEG},
           1'b1, ONE, 1'b0, 1'b0},
         '{2'd2, 31'd1, {32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
           1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd2, THR_MAX, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0},
           1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd1, 31'd1, {ONE, {8{32'hDEAD_BEEF}}}, 1'b1, ONE, 1'b0, 1'b0},
         '{2'd1, 31'd1, {32'd1, {8{32'd0}}}, 1'b1, MAX_POS, 1'b0, 1'b1},
         '{2'd1, 31'd1, {32'hFFFF_FFFF, {8{32'd0}}}, 1'b1, MAX_NEG, 1'b0, 1'b1},
         '{2'd1, 31'd1, {MAX_NEG, {8{32'd0}}}, 1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd1, 31'd0, {9{32'd0}}, 1'b1, 32'd0, 1'b1, 1'b0},
         '{2'd1, THR_MAX, {MAX_POS, {8{32'd0}}}, 1'b0, 32'd0, 1'b0, 1'b0},
         '{2'd0, 31'd1, {2 * ONE, {8{32'd0}}}, 1'b1, 32'h8000, 1'b0, 1'b0}
      };
      fail_count = 0; beats_in = 0; beats_out = 0; singular_seen = 0; sat_seen = 0;
      cur_order = 2'd3; cur_thresh = 31'd1;
      reset = 1'b1; req_valid = 1'b0; csr_wen = 1'b0;
      csr_index = smi_pkg::CSR_ORDER; csr_wdata = '0;
      {req_a00, req_a01, req_a02, req_a10, req_a11, req_a12, req_a20, req_a21, req_a22} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].order != cur_order || rows[i].thresh != cur_thresh)
            drain_and_configure(rows[i].order, rows[i].thresh);
         n = (rows[i].order == 0) ? 1 : int'(rows[i].order);
         typed_res.singular  = rows[i].sing;
         typed_res.saturated = rows[i].sat;
         for (int k = 0; k < 9; k++)
            typed_res.b[k] = (k % 4 == 0 && k / 3 < n) ? rows[i].diag : 32'd0;
         send_matrix(rows[i].m, $urandom_range(0, 4), rows[i].typed, typed_res);
      end

      quiet = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       drain_and_configure(phase_order[p], 31'd0);
            1:       drain_and_configure(phase_order[p], THR_MAX);
            2:       drain_and_configure(phase_order[p], 31'($urandom_range(0, 4096)));
            default: drain_and_configure(phase_order[p], 31'd1);
         endcase
         for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
            if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++) m[k] = rand_elem(mode);
            // near-singular: repeat row 0 in row 1 with a tiny nudge
            if (mode == 8) m[3:5] = {m[0], m[1], m[2] + 32'($urandom_range(0, 1))};
            gap = quiet ? 0 : $urandom_range(0, 4);
            send_matrix(m, gap, 1'b0, typed_res);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (inverse_q.size() != 0 && wait_cycles < 20 * IDLE_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (inverse_q.size() != 0) begin
         $error("%0d results never arrived", inverse_q.size());
         fail_count++;
      end
      $display("Sent %0d matrices over orders 0..3 and several thresholds; %0d results checked,",
               beats_in, beats_out);
      $display("%0d singular, %0d saturated, %0d mismatches.", singular_seen, sat_seen, fail_count);
      if (fail_count == 0) begin
         $display("PASS small_matrix_inverse_unit");
      end else begin
         $display("FAIL small_matrix_inverse_unit");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/smi_pkg.sv
rtl/smi_divider.sv
rtl/small_matrix_inverse_unit.sv
rtl/smi_checker.sv
tb/small_matrix_inverse_unit_tb.sv
